// ===== rtl/core/gdcs_pkg.sv =====
package gdcs_pkg;
    localparam int unsigned MAX_ELEMS_DEF = 64;
    localparam int unsigned VAL_W = 16;
    localparam int unsigned CNT_W = 11;
    localparam int unsigned QDEPTH = 2;

    // Entry handed from the load front end to the sort back end.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } gdcs_item_t;
endpackage

// ===== rtl/core/gdcs_queue.sv =====
module gdcs_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdcs_pkg::gdcs_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output gdcs_pkg::gdcs_item_t out_item
);
    gdcs_pkg::gdcs_item_t mem_reg [gdcs_pkg::QDEPTH];
    logic                 wp_reg, rp_reg;
    logic [1:0]           cnt_reg;
    logic                 push, pop;

    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !in_ready) else $error("full queue accepts");
    a_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !out_valid) else $error("empty queue shows data");
endmodule

// ===== rtl/core/gdcs_sorter.sv =====
module gdcs_sorter #(
    parameter int unsigned MAX_ELEMS = gdcs_pkg::MAX_ELEMS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  gdcs_pkg::gdcs_item_t     q_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [gdcs_pkg::VAL_W-1:0] m_value_res,
    output logic                     m_last_res,
    output logic [gdcs_pkg::CNT_W-1:0] m_comparisons,
    output logic [gdcs_pkg::CNT_W-1:0] m_swaps,
    output logic                     m_overflowed
);
    localparam int unsigned AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int unsigned NW = $clog2(MAX_ELEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD, S_RDA, S_RDB, S_CMP, S_EMIT_RD, S_EMIT
    } state_t;

    logic signed [gdcs_pkg::VAL_W-1:0] store [MAX_ELEMS];

    state_t                      state_reg;
    logic [NW-1:0]               n_reg;
    logic [AW-1:0]               gap_reg, i_reg;
    logic [AW:0]                 j_full;
    logic                        drop_reg;
    logic [gdcs_pkg::CNT_W-1:0]  cmp_reg, swp_reg;
    logic signed [gdcs_pkg::VAL_W-1:0] rd_reg, a_reg;
    logic [AW-1:0]               j_idx;

    // Second operand index of the current compare.
    assign j_full = {1'b0, i_reg} + {1'b0, gap_reg};
    assign j_idx  = j_full[AW-1:0];
    assign q_ready = (state_reg == S_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            n_reg     <= '0;
            drop_reg  <= 1'b0;
            m_valid   <= 1'b0;
            gap_reg   <= '0;
            i_reg     <= '0;
            cmp_reg   <= '0;
            swp_reg   <= '0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (q_valid) begin
                        logic [NW-1:0] n_new;
                        n_new = n_reg;
                        if (n_reg < NW'(MAX_ELEMS)) begin
                            store[n_reg[AW-1:0]] <= q_item.value;
                            n_new = n_reg + 1'b1;
                        end else begin
                            drop_reg <= 1'b1;
                        end
                        n_reg <= n_new;
                        if (q_item.last) begin
                            cmp_reg <= '0;
                            swp_reg <= '0;
                            i_reg   <= '0;
                            if (n_new > NW'(1)) begin
                                gap_reg   <= AW'(n_new - 1'b1);
                                state_reg <= S_RDA;
                            end else begin
                                state_reg <= S_EMIT_RD;
                            end
                        end
                    end
                end
                S_RDA: begin
                    rd_reg    <= store[i_reg];
                    state_reg <= S_RDB;
                end
                S_RDB: begin
                    a_reg     <= rd_reg;
                    rd_reg    <= store[j_idx];
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    cmp_reg <= cmp_reg + 1'b1;
                    if (a_reg > rd_reg) begin
                        store[i_reg] <= rd_reg;
                        store[j_idx] <= a_reg;
                        swp_reg <= swp_reg + 1'b1;
                    end
                    if ({1'b0, j_full} + 1'b1 < (AW+2)'(n_reg)) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RDA;
                    end else if (gap_reg > AW'(1)) begin
                        gap_reg   <= gap_reg - 1'b1;
                        i_reg     <= '0;
                        state_reg <= S_RDA;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    if (!m_valid || m_ready) begin
                        logic fin;
                        fin = ({1'b0, i_reg} + 1'b1 == (AW+1)'(n_reg));
                        m_valid       <= 1'b1;
                        m_value_res   <= store[i_reg];
                        m_last_res    <= fin;
                        m_comparisons <= fin ? cmp_reg : '0;
                        m_swaps       <= fin ? swp_reg : '0;
                        m_overflowed  <= fin ? drop_reg : 1'b0;
                        i_reg         <= i_reg + 1'b1;
                        if (fin) begin
                            n_reg     <= '0;
                            drop_reg  <= 1'b0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(MAX_ELEMS)) else $error("element count beyond capacity");
    a_swp_le_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        swp_reg <= cmp_reg) else $error("more swaps than compares");
    a_emit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_res |-> m_comparisons == '0 && m_swaps == '0)
        else $error("counts shown before final result");
    a_gap_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |-> gap_reg != '0) else $error("zero gap in sweep");
endmodule

// ===== rtl/core/gap_decrement_comb_sort_unit.sv =====
// Gap-decrement comb sort. Accepts one signed 16-bit value per transaction
// until one marked last, keeping up to MAX_ELEMS values (extras are dropped
// and reported on the final result). It then makes one compare-and-swap sweep
// for every gap from count-1 down to 1 and returns the values in store order;
// the final result carries compare and swap counts and the overflow flag.
// A front queue of two entries takes inputs while the sorter is loading;
// each value is stored as it is loaded, each compare reads its first operand,
// then its second, then compares and writes both back swapped if the first
// is greater, and results drain while the receiver is ready. The sorter
// takes no new set while a set is sorting or draining; meanwhile the queue
// still takes up to two transactions of the next set and then holds s_ready low.
module gap_decrement_comb_sort_unit #(
    parameter int unsigned MAX_ELEMS = gdcs_pkg::MAX_ELEMS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [15:0]         s_value,
    input  logic                       s_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [15:0]         m_value_res,
    output logic                       m_last_res,
    output logic [10:0]                m_comparisons,
    output logic [10:0]                m_swaps,
    output logic                       m_overflowed
);
    gdcs_pkg::gdcs_item_t in_item, q_item;
    logic                 q_valid, q_ready;

    assign in_item.value = s_value;
    assign in_item.last  = s_last;

    // Front end: hold incoming transactions until the sorter takes them.
    gdcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Back end: store, sweep and drain.
    gdcs_sorter #(.MAX_ELEMS(MAX_ELEMS)) u_sorter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_res   (m_value_res),
        .m_last_res    (m_last_res),
        .m_comparisons (m_comparisons),
        .m_swaps       (m_swaps),
        .m_overflowed  (m_overflowed)
    );
endmodule
